// ===== hw/rtl/ltm_pkg.sv =====
// Shared types, codes and widths for the learner transition-matrix row block.
package ltm_pkg;

  localparam int FUNC_W   = 2;
  localparam int FIRST_W  = 8;
  localparam int SECOND_W = 4;
  localparam int Q16_W    = 17;
  localparam int STATE_W  = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [Q16_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [Q16_W-1:0] ZERO_Q16 = 17'h00000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DATA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENVIRONMENT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEDY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ADJ      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SURFACE  = 3'd5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_UNDER = 2'd0,
    FUNC_SURF  = 2'd1,
    FUNC_ADJ   = 2'd2,
    FUNC_ROW   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK  = 2'd0,
    STATUS_ROW = 2'd1,
    STATUS_ENV = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMW_RD,
    S_RMW_WR,
    S_ADJ_RD,
    S_KCOUNT,
    S_COL,
    S_ACC,
    S_DIV,
    S_COL_WR,
    S_DIAG,
    S_OUT_RD,
    S_OUT_LD,
    S_ERR
  } state_t;

endpackage

// ===== hw/rtl/ltm_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface ltm_in_if import ltm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [FIRST_W-1:0]  first_index;
  logic [SECOND_W-1:0] second_index;
  logic [Q16_W-1:0]    cell_value;

  modport source (output valid, output func, output first_index, output second_index,
                  output cell_value, input ready);
  modport sink   (input valid, input func, input first_index, input second_index,
                  input cell_value, output ready);
endinterface

interface ltm_out_if import ltm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATE_W-1:0]  row_state;
  logic [STATE_W-1:0]  col_state;
  logic [Q16_W-1:0]    probability;
  logic                last;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output row_state, output col_state, output probability,
                  output last, output status, input ready);
  modport sink   (input valid, input row_state, input col_state, input probability,
                  input last, input status, output ready);
endinterface

// ===== hw/rtl/learner_transition_matrix_row.sv =====
// Top level: transition-matrix row generator for a triggering learner as a Markov chain.
//
// Usage. Items arrive on req (valid/ready), results leave on rsp (valid/ready); the
// six registers are written through cfg_we/cfg_index/cfg_data, and the user must
// write them only while the block is idle: the block itself does not enforce it.
// Cell loads (func 0, 1) fill the per-datum acceptance bits and weights, adjacency
// loads (func 2) fill the adjacency matrix, a compute (func 3) for state i emits row i
// as one transaction per target state, in column order, with last on the final one.
// An environment or row index out of range yields a single transaction with status set.
// Timing. A surface load is written in the cycle that takes it, an underlying or
// adjacency load is a read-modify-write of one RAM word. A compute's length is set
// by the one weight accumulator that sweeps the data RAMs one datum a cycle and by
// the 17-step shift-subtract divider. The last result sits in an output register;
// the next item is taken while it waits. A stalled receiver holds rsp and freezes
// the row emission until it takes the result. Reset (synchronous, active high)
// loads the register defaults and empties the output; the RAMs are not cleared and
// hold nothing meaningful until written.
module learner_transition_matrix_row import ltm_pkg::*; #(
  parameter int MAX_STATES = 16,
  parameter int MAX_DATA   = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  ltm_in_if.sink                req,
  ltm_out_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SAW = $clog2(MAX_STATES);
  localparam int SCW = $clog2(MAX_STATES + 1);
  localparam int DAW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int DCW = $clog2(MAX_DATA + 1);

  // Saturate a grown sum at 1.0
  function automatic logic [Q16_W-1:0] sat_one(input logic [Q16_W:0] v);
    return (v > {1'b0, ONE_Q16}) ? ONE_Q16 : v[Q16_W-1:0];
  endfunction

  // Configuration registers
  logic [4:0] num_states;
  logic [8:0] num_data;
  logic [3:0] environment;
  logic       greedy;
  logic       use_adjacency;
  logic       use_surface;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states    <= 5'd2;
      num_data      <= 9'd1;
      environment   <= 4'd0;
      greedy        <= 1'b0;
      use_adjacency <= 1'b0;
      use_surface   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_STATES:  num_states    <= cfg_data[4:0];
        CFG_NUM_DATA:    num_data      <= cfg_data[8:0];
        CFG_ENVIRONMENT: environment   <= cfg_data[3:0];
        CFG_GREEDY:      greedy        <= cfg_data[0];
        CFG_USE_ADJ:     use_adjacency <= cfg_data[0];
        CFG_USE_SURFACE: use_surface   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero states act as one, counts clamp at the store sizes
  logic [SCW-1:0] n_eff;
  logic [DCW-1:0] nd_eff;

  always_comb begin
    if (num_states == 5'd0) begin
      n_eff = SCW'(1);
    end else if (32'(num_states) > MAX_STATES) begin
      n_eff = SCW'(MAX_STATES);
    end else begin
      n_eff = SCW'(num_states);
    end
    nd_eff = (32'(num_data) > MAX_DATA) ? DCW'(MAX_DATA) : DCW'(num_data);
  end

  // Sequencer and datapath registers
  state_t             state, state_next;
  func_t              op, op_next;
  logic [FIRST_W-1:0]  idx_a, idx_a_next;
  logic [SECOND_W-1:0] idx_b, idx_b_next;
  logic                cell_on, cell_on_next;
  logic [SCW-1:0]      n_st, n_st_next;
  logic [DCW-1:0]      n_dat, n_dat_next;
  logic [SCW-1:0]      k_cnt, k_cnt_next;
  logic [SCW-1:0]      col, col_next;
  logic [DCW-1:0]      dat, dat_next;
  logic                pend, pend_next;
  logic [Q16_W-1:0]    sum, sum_next;
  logic [Q16_W-1:0]    total, total_next;
  logic [Q16_W-1:0]    quo, quo_next;
  logic [SCW-1:0]      rem, rem_next;
  logic [4:0]          step, step_next;
  status_t             err, err_next;

  // Output register
  logic                out_valid, out_valid_next;
  logic [STATE_W-1:0]  out_row, out_row_next;
  logic [STATE_W-1:0]  out_col, out_col_next;
  logic [Q16_W-1:0]    out_prob, out_prob_next;
  logic                out_last, out_last_next;
  status_t             out_status, out_status_next;

  // RAM ports
  logic                  acc_we;
  logic [DAW-1:0]        acc_raddr;
  logic [MAX_STATES-1:0] acc_wdata, acc_rdata;
  logic                  wgt_we;
  logic [DAW-1:0]        wgt_waddr;
  logic [Q16_W-1:0]      wgt_wdata, wgt_rdata;
  logic                  adj_we;
  logic [MAX_STATES-1:0] adj_wdata, adj_rdata;
  logic                  row_we;
  logic [SAW-1:0]        row_waddr;
  logic [Q16_W-1:0]      row_wdata, row_rdata;

  logic                  in_ready;

  // Acceptance bits per datum, one per grammar
  ltm_ram #(.WIDTH(MAX_STATES), .DEPTH(MAX_DATA)) u_accept (
    .clk   (clk),
    .we    (acc_we),
    .waddr (DAW'(idx_a)),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Weight per datum from the environment column
  ltm_ram #(.WIDTH(Q16_W), .DEPTH(MAX_DATA)) u_weight (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (wgt_wdata),
    .raddr (DAW'(dat)),
    .rdata (wgt_rdata)
  );

  // Adjacency rows; the source state is the latched first index throughout
  ltm_ram #(.WIDTH(MAX_STATES), .DEPTH(MAX_STATES)) u_adjacent (
    .clk   (clk),
    .we    (adj_we),
    .waddr (SAW'(idx_a)),
    .wdata (adj_wdata),
    .raddr (SAW'(idx_a)),
    .rdata (adj_rdata)
  );

  // Entries of the row under construction
  ltm_ram #(.WIDTH(Q16_W), .DEPTH(MAX_STATES)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (SAW'(col)),
    .rdata (row_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      pend      <= pend_next;
    end
    op         <= op_next;
    idx_a      <= idx_a_next;
    idx_b      <= idx_b_next;
    cell_on    <= cell_on_next;
    n_st       <= n_st_next;
    n_dat      <= n_dat_next;
    k_cnt      <= k_cnt_next;
    col        <= col_next;
    dat        <= dat_next;
    sum        <= sum_next;
    total      <= total_next;
    quo        <= quo_next;
    rem        <= rem_next;
    step       <= step_next;
    err        <= err_next;
    out_row    <= out_row_next;
    out_col    <= out_col_next;
    out_prob   <= out_prob_next;
    out_last   <= out_last_next;
    out_status <= out_status_next;
  end

  // Sequencer: next state, datapath updates and RAM controls
  logic               in_cell_range;
  logic               in_adj_range;
  logic               env_hit;
  logic [SAW-1:0]     src_i;
  logic [SAW-1:0]     col_i;
  logic               out_free;
  logic [SCW:0]       rshift;
  logic [SCW:0]       rdiff;
  logic               col_skip;
  logic               data_issue;

  always_comb begin
    state_next      = state;
    op_next         = op;
    idx_a_next      = idx_a;
    idx_b_next      = idx_b;
    cell_on_next    = cell_on;
    n_st_next       = n_st;
    n_dat_next      = n_dat;
    k_cnt_next      = k_cnt;
    col_next        = col;
    dat_next        = dat;
    pend_next       = pend;
    sum_next        = sum;
    total_next      = total;
    quo_next        = quo;
    rem_next        = rem;
    step_next       = step;
    err_next        = err;
    out_valid_next  = out_valid && !rsp.ready;
    out_row_next    = out_row;
    out_col_next    = out_col;
    out_prob_next   = out_prob;
    out_last_next   = out_last;
    out_status_next = out_status;

    in_ready  = 1'b0;
    acc_we    = 1'b0;
    acc_raddr = DAW'(idx_a);
    acc_wdata = acc_rdata;
    wgt_we    = 1'b0;
    wgt_waddr = DAW'(req.first_index);
    wgt_wdata = sat_one({1'b0, req.cell_value});
    adj_we    = 1'b0;
    adj_wdata = adj_rdata;
    row_we    = 1'b0;
    row_waddr = SAW'(col);
    row_wdata = quo;

    in_cell_range = (32'(req.first_index) < MAX_DATA) && (32'(req.second_index) < MAX_STATES);
    in_adj_range  = (32'(req.first_index) < MAX_STATES) && (32'(req.second_index) < MAX_STATES);
    env_hit       = (req.second_index == environment);
    src_i         = SAW'(idx_a);
    col_i         = SAW'(col);
    out_free      = !out_valid || rsp.ready;
    rshift        = {rem, quo[Q16_W-1]};
    rdiff         = rshift - {1'b0, k_cnt};
    col_skip      = (col_i == src_i) || (k_cnt == '0) || (use_adjacency && !adj_rdata[col_i]);
    data_issue    = (dat < n_dat);

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (req.valid) begin
          op_next      = func_t'(req.func);
          idx_a_next   = req.first_index;
          idx_b_next   = req.second_index;
          cell_on_next = (req.cell_value != '0);
          unique case (func_t'(req.func))
            FUNC_UNDER: begin
              if (in_cell_range) begin
                wgt_we     = env_hit && !use_surface;
                state_next = S_RMW_RD;
              end
            end
            FUNC_SURF: begin
              wgt_we = in_cell_range && env_hit && use_surface;
            end
            FUNC_ADJ: begin
              if (in_adj_range) begin
                state_next = S_RMW_RD;
              end
            end
            FUNC_ROW: begin
              n_st_next  = n_eff;
              n_dat_next = nd_eff;
              if (32'(environment) >= 32'(n_eff)) begin
                err_next   = STATUS_ENV;
                state_next = S_ERR;
              end else if (32'(req.first_index) >= 32'(n_eff)) begin
                err_next   = STATUS_ROW;
                state_next = S_ERR;
              end else begin
                state_next = S_ADJ_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_RMW_RD: begin
        // read the word that the load modifies
        state_next = S_RMW_WR;
      end

      S_RMW_WR: begin
        if (op == FUNC_UNDER) begin
          acc_we = 1'b1;
          acc_wdata[SAW'(idx_b)] = cell_on;
        end else begin
          adj_we = 1'b1;
          adj_wdata[SAW'(idx_b)] = cell_on;
        end
        state_next = S_IDLE;
      end

      S_ADJ_RD: begin
        col_next   = '0;
        k_cnt_next = '0;
        state_next = S_KCOUNT;
      end

      S_KCOUNT: begin
        // count the states reachable from the source
        if (col < n_st) begin
          if ((col_i != src_i) && adj_rdata[col_i]) begin
            k_cnt_next = k_cnt + SCW'(1);
          end
          col_next = col + SCW'(1);
        end else begin
          if (!use_adjacency) begin
            k_cnt_next = n_st - SCW'(1);
          end
          col_next   = '0;
          total_next = '0;
          state_next = S_COL;
        end
      end

      S_COL: begin
        if (col == n_st) begin
          state_next = S_DIAG;
        end else if (col_skip) begin
          row_we    = 1'b1;
          row_wdata = ZERO_Q16;
          col_next  = col + SCW'(1);
        end else begin
          sum_next   = '0;
          dat_next   = '0;
          pend_next  = 1'b0;
          state_next = S_ACC;
        end
      end

      S_ACC: begin
        // one datum a cycle: issue the read, accumulate the one returned
        acc_raddr = DAW'(dat);
        pend_next = data_issue;
        if (data_issue) begin
          dat_next = dat + DCW'(1);
        end
        if (pend && !acc_rdata[src_i] && (!greedy || acc_rdata[col_i])) begin
          sum_next = sat_one({1'b0, sum} + {1'b0, wgt_rdata});
        end
        if (!data_issue && !pend) begin
          quo_next   = sum;
          rem_next   = '0;
          step_next  = '0;
          state_next = S_DIV;
        end
      end

      S_DIV: begin
        // restoring division by the reachable count, one quotient bit a cycle
        if (rshift >= {1'b0, k_cnt}) begin
          rem_next = SCW'(rdiff);
          quo_next = {quo[Q16_W-2:0], 1'b1};
        end else begin
          rem_next = SCW'(rshift);
          quo_next = {quo[Q16_W-2:0], 1'b0};
        end
        step_next = step + 5'd1;
        if (step == 5'(Q16_W - 1)) begin
          state_next = S_COL_WR;
        end
      end

      S_COL_WR: begin
        row_we     = 1'b1;
        row_wdata  = quo;
        total_next = sat_one({1'b0, total} + {1'b0, quo});
        col_next   = col + SCW'(1);
        state_next = S_COL;
      end

      S_DIAG: begin
        row_we     = 1'b1;
        row_waddr  = src_i;
        row_wdata  = ONE_Q16 - total;
        col_next   = '0;
        state_next = S_OUT_RD;
      end

      S_OUT_RD: begin
        state_next = S_OUT_LD;
      end

      S_OUT_LD: begin
        // hold the entry until the output register is free
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_row_next    = idx_a[STATE_W-1:0];
          out_col_next    = STATE_W'(col);
          out_prob_next   = row_rdata;
          out_last_next   = (col == n_st - SCW'(1));
          out_status_next = STATUS_OK;
          if (col == n_st - SCW'(1)) begin
            state_next = S_IDLE;
          end else begin
            col_next   = col + SCW'(1);
            state_next = S_OUT_RD;
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_row_next    = idx_a[STATE_W-1:0];
          out_col_next    = '0;
          out_prob_next   = ZERO_Q16;
          out_last_next   = 1'b1;
          out_status_next = err;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req.ready       = in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.row_state   = out_row;
  assign rsp.col_state   = out_col;
  assign rsp.probability = out_prob;
  assign rsp.last        = out_last;
  assign rsp.status      = out_status;

endmodule

// ===== hw/rtl/ltm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ltm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/learner_transition_matrix_row_test.sv =====
// Self-checking testbench for the learner transition-matrix row block.
`timescale 1ns / 1ps

module learner_transition_matrix_row_test;
  import ltm_pkg::*;

  // Store sizes of the block at its default parameters
  localparam int MAX_STATES = 16;
  localparam int MAX_DATA   = 256;
  // Part of the stores that is written in full before any row reads it
  localparam int FILL_DATA   = 4;
  localparam int FILL_STATES = 5;
  // Cycles with no transaction and no register write before the run is declared hung.
  // The slowest row here has 16 states and 4 data.
  localparam int QUIET_LIMIT = 2000;
  // Cycles to let an underlying or adjacency load retire once nothing is pending
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [STATE_W-1:0] row;
    logic [STATE_W-1:0] col;
    logic [Q16_W-1:0]   prob;
    logic               last;
    status_t            status;
  } row_entry_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ltm_in_if  req_ch ();
  ltm_out_if rsp_ch ();

  learner_transition_matrix_row i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the stores and of the registers.
  // ---------------------------------------------------------------------------
  logic [MAX_STATES-1:0] accept_mem   [MAX_DATA];
  logic [Q16_W-1:0]      weight_mem   [MAX_DATA];
  logic [MAX_STATES-1:0] adjacent_mem [MAX_STATES];

  // Register copies start at the reset defaults of the block
  logic [4:0] n_states_reg = 5'd2;
  logic [8:0] n_data_reg   = 9'd1;
  logic [3:0] env_reg      = 4'd0;
  logic       greedy_reg   = 1'b0;
  logic       adj_on_reg   = 1'b0;
  logic       surface_reg  = 1'b0;

  // Matrix entries still owed by the block, oldest first
  row_entry_t pending_entries[$];

  int mismatches = 0;
  int burst_left = 0;

  function automatic logic [Q16_W-1:0] sat_q16(int unsigned v);
    return (v > ONE_Q16) ? ONE_Q16 : v[Q16_W-1:0];
  endfunction

  function automatic int unsigned eff_states(logic [4:0] v);
    return (v == 0) ? 1 : ((32'(v) > MAX_STATES) ? MAX_STATES : 32'(v));
  endfunction

  // Work out row src of the transition matrix and queue its entries
  function automatic void predict_row(logic [FIRST_W-1:0] src);
    int unsigned n, nd, k, total, sum;
    logic [Q16_W-1:0] entry [MAX_STATES];
    row_entry_t e;
    n  = eff_states(n_states_reg);
    nd = (n_data_reg > MAX_DATA) ? MAX_DATA : 32'(n_data_reg);
    // Environment column is checked before the row index
    if (env_reg >= n || src >= n) begin
      e.row    = src[STATE_W-1:0];
      e.col    = '0;
      e.prob   = ZERO_Q16;
      e.last   = 1'b1;
      e.status = (env_reg >= n) ? STATUS_ENV : STATUS_ROW;
      pending_entries.push_back(e);
      return;
    end
    // Count the states the learner may step to
    if (adj_on_reg) begin
      k = 0;
      for (int j = 0; j < n; j++)
        if (j != src && adjacent_mem[src][j]) k++;
    end else begin
      k = n - 1;
    end
    total = 0;
    for (int j = 0; j < n; j++) begin
      sum = 0;
      entry[j] = ZERO_Q16;
      if (j == src || k == 0) continue;
      if (adj_on_reg && !adjacent_mem[src][j]) continue;
      for (int m = 0; m < nd; m++) begin
        if (accept_mem[m][src]) continue;
        if (greedy_reg && !accept_mem[m][j]) continue;
        sum = 32'(sat_q16(sum + 32'(weight_mem[m])));
      end
      // One division per entry, truncating
      entry[j] = Q16_W'(sum / k);
      total = 32'(sat_q16(total + 32'(entry[j])));
    end
    entry[src] = ONE_Q16 - Q16_W'(total);
    for (int j = 0; j < n; j++) begin
      e.row    = src[STATE_W-1:0];
      e.col    = 4'(j);
      e.prob   = entry[j];
      e.last   = (j == n - 1);
      e.status = STATUS_OK;
      pending_entries.push_back(e);
    end
  endfunction

  // Advance the predictor by one accepted input transaction
  function automatic void apply_item(func_t f, logic [FIRST_W-1:0] a,
                                     logic [SECOND_W-1:0] b, logic [Q16_W-1:0] c);
    case (f) inside
      FUNC_UNDER, FUNC_SURF: begin
        if (f == FUNC_UNDER) accept_mem[a][b] = (c != 0);
        if (b == env_reg && surface_reg == (f == FUNC_SURF)) weight_mem[a] = sat_q16(32'(c));
      end
      FUNC_ADJ: begin
        // Source states beyond the store are dropped
        if (a < MAX_STATES) adjacent_mem[a][b] = (c != 0);
      end
      default: predict_row(a);
    endcase
  endfunction

  // Cell values: zero, exactly one, above one (saturates), mid range, small weights
  function automatic logic [Q16_W-1:0] random_cell();
    case ($urandom_range(0, 7))
      0:       return ZERO_Q16;
      1:       return ONE_Q16;
      2:       return 17'($urandom_range(65537, 131071));
      3:       return 17'($urandom_range(1, 65535));
      default: return 17'($urandom_range(1, 3000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one transaction per call, in bursts of random length with gaps.
  // Call right after a rising edge; returns at the edge that took the item or after a gap.
  // ---------------------------------------------------------------------------
  task automatic send_item(func_t f, logic [FIRST_W-1:0] a, logic [SECOND_W-1:0] b,
                           logic [Q16_W-1:0] c);
    int gap;
    req_ch.valid        <= 1'b1;
    req_ch.func         <= f;
    req_ch.first_index  <= a;
    req_ch.second_index <= b;
    req_ch.cell_value   <= c;
    do @(posedge clk); while (!req_ch.ready);
    apply_item(f, a, b, c);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // Long bursts leave stretches with no idling at all
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every owed entry has arrived
  task automatic pause_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_entries.size() != 0);
  endtask

  // Drain, then let a trailing load retire so the block is idle
  task automatic wait_idle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 9'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_NUM_STATES:  n_states_reg = 5'(val);
      CFG_NUM_DATA:    n_data_reg   = 9'(val);
      CFG_ENVIRONMENT: env_reg      = 4'(val);
      CFG_GREEDY:      greedy_reg   = val[0];
      CFG_USE_ADJ:     adj_on_reg   = val[0];
      CFG_USE_SURFACE: surface_reg  = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned ns, int unsigned nd, int unsigned env,
                            int unsigned g, int unsigned adj, int unsigned surf);
    wait_idle();
    write_reg(CFG_NUM_STATES, ns);
    write_reg(CFG_NUM_DATA, nd);
    write_reg(CFG_ENVIRONMENT, env);
    write_reg(CFG_GREEDY, g);
    write_reg(CFG_USE_ADJ, adj);
    write_reg(CFG_USE_SURFACE, surf);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The stores power up undefined. Write the acceptance bits of the first states
  // for the first data, and the adjacency rows among the first states; every row
  // below reads only these words, or no data at all.
  task automatic fill_stores();
    for (int m = 0; m < FILL_DATA; m++)
      for (int c = 0; c < FILL_STATES; c++)
        send_item(FUNC_UNDER, 8'(m), 4'(c), ($urandom_range(0, 1) == 0) ? ZERO_Q16
                                                                         : random_cell());
    for (int s = 0; s < FILL_STATES; s++)
      for (int t = 0; t < FILL_STATES; t++)
        send_item(FUNC_ADJ, 8'(s), 4'(t), ($urandom_range(0, 2) == 0) ? ZERO_Q16
                                                                       : random_cell());
    // Reload the weights from surface cells so they no longer track column 0
    wait_idle();
    write_reg(CFG_USE_SURFACE, 1);
    for (int m = 0; m < FILL_DATA; m++)
      send_item(FUNC_SURF, 8'(m), 4'd0, random_cell());
    wait_idle();
    write_reg(CFG_USE_SURFACE, 0);
  endtask

  // Registers at their reset values: two states, one datum
  task automatic check_default_rows();
    send_item(FUNC_ROW, 8'd0, 4'd0, ZERO_Q16);
    send_item(FUNC_ROW, 8'd1, 4'd15, 17'h1FFFF);
    send_item(FUNC_ROW, 8'd2, 4'd0, ZERO_Q16);
    send_item(FUNC_ROW, 8'd255, 4'd0, ZERO_Q16);
  endtask

  // Largest matrix, then register values above the store sizes
  task automatic check_extreme_sizes();
    set_config(16, FILL_DATA, 15, 0, 0, 0);
    send_item(FUNC_ROW, 8'd4, 4'd0, ZERO_Q16);
    send_item(FUNC_ROW, 8'd0, 4'd0, ZERO_Q16);
    set_config(16, 0, 15, 1, 0, 0);
    send_item(FUNC_ROW, 8'd15, 4'd0, ZERO_Q16);
    // State count above the store acts as the full store
    set_config(31, 0, 0, 0, 0, 1);
    send_item(FUNC_SURF, 8'd255, 4'd0, 17'h1FFFF);
    send_item(FUNC_ADJ, 8'd255, 4'd3, ONE_Q16);
    send_item(FUNC_ROW, 8'd15, 4'd0, ZERO_Q16);
    // Data count above the store with a single state: the row is the diagonal
    set_config(1, 511, 0, 0, 0, 0);
    send_item(FUNC_ROW, 8'd0, 4'd0, ZERO_Q16);
  endtask

  task automatic check_special_cases();
    // A zero state count acts as a single state: the row is the diagonal alone
    set_config(0, 4, 0, 0, 0, 0);
    send_item(FUNC_ROW, 8'd0, 4'd0, ZERO_Q16);
    send_item(FUNC_ROW, 8'd1, 4'd0, ZERO_Q16);
    // No data: every off-diagonal entry is zero
    set_config(4, 0, 1, 1, 0, 0);
    send_item(FUNC_ROW, 8'd3, 4'd0, ZERO_Q16);
    // Environment beyond the state count wins over a bad row index
    set_config(4, 8, 5, 0, 0, 0);
    send_item(FUNC_ROW, 8'd2, 4'd0, ZERO_Q16);
    send_item(FUNC_ROW, 8'd9, 4'd0, ZERO_Q16);
    // No adjacent state: the learner stays put; then one neighbor
    set_config(2, 4, 0, 0, 1, 0);
    send_item(FUNC_ADJ, 8'd1, 4'd0, ZERO_Q16);
    send_item(FUNC_ROW, 8'd1, 4'd0, ZERO_Q16);
    send_item(FUNC_ADJ, 8'd1, 4'd0, ONE_Q16);
    send_item(FUNC_ROW, 8'd1, 4'd0, ZERO_Q16);
    // Weight sum saturates at one before the division, diagonal lands on zero
    set_config(3, 2, 1, 0, 0, 0);
    send_item(FUNC_UNDER, 8'd0, 4'd1, ONE_Q16);
    send_item(FUNC_UNDER, 8'd1, 4'd1, 17'h1FFFF);
    send_item(FUNC_UNDER, 8'd0, 4'd0, ZERO_Q16);
    send_item(FUNC_UNDER, 8'd1, 4'd0, ZERO_Q16);
    send_item(FUNC_ROW, 8'd0, 4'd0, ZERO_Q16);
  endtask

  // Random register settings per phase, random loads and rows within each phase.
  // Matrices wider than the filled states run plain (no greedy, no adjacency) and
  // read data only from rows of the filled states.
  task automatic run_random_phases();
    int unsigned ns, nd, env, n_eff, pick, g, adj;
    logic wide;
    func_t f;
    logic [FIRST_W-1:0] a;
    logic [SECOND_W-1:0] b;
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 7))
        0:       ns = 0;
        1:       ns = 1;
        2:       ns = 16;
        3:       ns = $urandom_range(17, 31);
        default: ns = $urandom_range(2, FILL_STATES);
      endcase
      case ($urandom_range(0, 4))
        0:       nd = 0;
        1:       nd = FILL_DATA;
        default: nd = $urandom_range(1, FILL_DATA);
      endcase
      n_eff = eff_states(5'(ns));
      wide  = (n_eff > FILL_STATES);
      g     = wide ? 0 : $urandom_range(0, 1);
      adj   = wide ? 0 : $urandom_range(0, 1);
      env = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n_eff - 1);
      set_config(ns, nd, env, g, adj, $urandom_range(0, 1));
      for (int it = 0; it < 13; it++) begin
        // Once, let every owed entry come back mid-phase
        if (p == 2 && it == 6) pause_until_drained();
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
          f = FUNC_ROW;
          if ($urandom_range(0, 7) == 0)
            a = 8'($urandom_range(n_eff, 255));
          else if (wide && nd != 0)
            a = 8'($urandom_range(0, FILL_STATES - 1));
          else
            a = 8'($urandom_range(0, n_eff - 1));
          b = 4'($urandom_range(0, 15));
        end else if (pick < 15) begin
          f = (pick < 12) ? FUNC_UNDER : FUNC_SURF;
          a = 8'($urandom_range(0, FILL_DATA - 1));
          b = ($urandom_range(0, 1) == 0) ? env_reg : 4'($urandom_range(0, 15));
        end else begin
          f = FUNC_ADJ;
          a = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                          : 8'($urandom_range(0, FILL_STATES - 1));
          b = 4'($urandom_range(0, 15));
        end
        send_item(f, a, b, random_cell());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a rotating stall pattern, reloaded when its age runs out.
  // A quarter of the patterns never stall.
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] stall_pat;
    int pat_age;
    stall_pat = 16'hFFFF;
    pat_age = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
        pat_age = 48;
      end
      rsp_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      pat_age--;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking against the oldest owed entry
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, logic [Q16_W-1:0] want,
                                      logic [Q16_W-1:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    row_entry_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_entries.size() == 0) begin
        if (mismatches < 10)
          $display("result with nothing owed: row %0d col %0d prob %0d",
                   rsp_ch.row_state, rsp_ch.col_state, rsp_ch.probability);
        mismatches++;
      end else begin
        want = pending_entries.pop_front();
        check_field("row_state", Q16_W'(want.row), Q16_W'(rsp_ch.row_state));
        check_field("col_state", Q16_W'(want.col), Q16_W'(rsp_ch.col_state));
        check_field("probability", want.prob, rsp_ch.probability);
        check_field("last", Q16_W'(want.last), Q16_W'(rsp_ch.last));
        check_field("status", Q16_W'(want.status), Q16_W'(rsp_ch.status));
      end
    end
  end

  // Watchdog: any transaction or register write counts as progress
  always @(posedge clk) begin
    int quiet;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, fill the stores, directed checks, random phases
  // ---------------------------------------------------------------------------
  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.func         <= FUNC_UNDER;
    req_ch.first_index  <= '0;
    req_ch.second_index <= '0;
    req_ch.cell_value   <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_NUM_STATES;
    cfg_data            <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    fill_stores();
    check_default_rows();
    check_extreme_sizes();
    check_special_cases();
    run_random_phases();

    // Drain, then give a trailing load time to finish
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== learner_transition_matrix_row.f =====
hw/rtl/ltm_pkg.sv
hw/rtl/ltm_if.sv
hw/rtl/ltm_ram.sv
hw/rtl/learner_transition_matrix_row.sv
dv/learner_transition_matrix_row_test.sv
